/* rtl/core/spwq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority work queue package
// Sizes, action and status codes, cell command and slot types shared by the
// queue cells and the top level.
// ----------------------------------------------------------------------------
package spwq_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int ACT_W  = 2;
    localparam int TAG_W  = 8;
    localparam int PRIO_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Request action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TAKE   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_DUP  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_cell_op            op;
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
    } t_cell_cmd;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
    } t_slot;

endpackage
`default_nettype wire

/* rtl/core/spwq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue cell
// Holds one slot of the sorted queue; shifts toward the back on insert and
// toward the front on delete, using only its two neighbors.
// ----------------------------------------------------------------------------
module spwq_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire spwq_pkg::t_cell_cmd     i_cmd,
    input  wire spwq_pkg::t_slot         i_left,
    input  wire logic                    i_left_ins,
    input  wire spwq_pkg::t_slot         i_right,
    input  wire logic                    i_hit,
    output spwq_pkg::t_slot              o_slot,
    output logic                         o_ins,
    output logic                         o_hit
);
    import spwq_pkg::*;

    logic                r_valid;
    logic [TAG_W-1:0]    r_tag;
    logic [PRIO_W-1:0]   r_prio;
    logic                n_valid;
    logic [TAG_W-1:0]    n_tag;
    logic [PRIO_W-1:0]   n_prio;
    logic                w_match;

    assign o_slot  = '{valid: r_valid, tag: r_tag, prio: r_prio};
    assign w_match = r_valid && (r_tag == i_cmd.tag);
    // Empty slots count as "at or below" so the insert point is monotonic
    assign o_ins   = !r_valid || (r_prio <= i_cmd.prio);
    assign o_hit   = i_hit | w_match;

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_prio  = r_prio;
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (o_ins) begin
                    if (i_left_ins) begin
                        n_tag  = i_left.tag;
                        n_prio = i_left.prio;
                    end else begin
                        n_tag  = i_cmd.tag;
                        n_prio = i_cmd.prio;
                    end
                    n_valid = r_valid | i_left.valid;
                end
            end
            CELL_DELETE: begin
                if (o_hit) begin
                    n_valid = i_right.valid;
                    n_tag   = i_right.tag;
                    n_prio  = i_right.prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

endmodule
`default_nettype wire

/* rtl/core/sorted_priority_work_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority work queue
// Chain of queue cells kept in descending priority order, with insert,
// remove-by-tag and conditional take of the front entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request transaction:
//   action (insert, remove, take), tag, priority for insert, and the minimum
//   priority a take requires. Output channel (o_out_valid / i_out_ready)
//   returns exactly one result transaction per request: status, the taken
//   tag and priority (zero unless a take succeeds) and the occupancy after
//   the request.
//   Flow: the request is registered on acceptance, every cell compares
//   against it in the execute state and the whole chain shifts in the same
//   edge that loads the result register. One request is in flight at a
//   time: a new request is not accepted until the current one has been
//   committed to the cell chain. The tag search and the insert point are
//   resolved across all cells combinationally, independent of occupancy.
//   The result register decouples the two sides: a new request is accepted
//   while a previous result still waits. If the receiver stalls, the block
//   holds its next request in the execute state until the result register
//   frees up.
//   Reset (synchronous, active low) empties the queue at once by clearing
//   the per-cell valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_work_queue_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [spwq_pkg::ACT_W-1:0]    i_action,
    input  wire logic [spwq_pkg::TAG_W-1:0]    i_tag,
    input  wire logic [spwq_pkg::PRIO_W-1:0]   i_priority_req,
    input  wire logic [spwq_pkg::PRIO_W-1:0]   i_min_priority,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [spwq_pkg::STAT_W-1:0]        o_status,
    output logic [spwq_pkg::TAG_W-1:0]         o_out_tag,
    output logic [spwq_pkg::PRIO_W-1:0]        o_out_priority,
    output logic [spwq_pkg::OCC_W-1:0]         o_occupancy
);
    import spwq_pkg::*;

    // Control state
    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    // Registered request
    logic [ACT_W-1:0]    r_req_action;
    logic [TAG_W-1:0]    r_req_tag;
    logic [PRIO_W-1:0]   r_req_prio;
    logic [PRIO_W-1:0]   r_req_min;

    // Result register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [TAG_W-1:0]    r_out_tag;
    logic [PRIO_W-1:0]   r_out_prio;
    logic [CNT_W-1:0]    r_out_count;

    // Decode of the request against the cell chain
    logic                w_accept;
    logic                w_commit;
    t_status             w_status;
    t_cell_op            w_op;
    logic [TAG_W-1:0]    w_res_tag;
    logic [PRIO_W-1:0]   w_res_prio;
    logic                w_found;
    logic                w_full;
    logic                w_front_ok;
    t_cell_cmd           w_cmd;

    // Chain wiring
    t_slot               w_slot [QUEUE_DEPTH];
    logic                w_ins  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] w_hit;
    logic [QUEUE_DEPTH-1:0] w_valid_vec;
    logic [QUEUE_DEPTH-1:0] w_order_ok;
    t_slot               w_head;
    t_slot               w_tail;

    // Cell 0 sees a full, never-qualifying neighbor so it is the insert point
    // when its own entry is at or below the new priority.
    assign w_head = '{valid: 1'b1, tag: '0, prio: '0};
    assign w_tail = '{valid: 1'b0, tag: '0, prio: '0};

    // A take deletes the front, so seed the hit chain at cell 0
    assign w_hit[0] = (r_req_action == ACT_TAKE);

    assign w_cmd = '{op: w_commit ? w_op : CELL_HOLD, tag: r_req_tag, prio: r_req_prio};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_ins;

        if (g == 0) begin : g_first
            assign w_left     = w_head;
            assign w_left_ins = 1'b0;
        end else begin : g_mid
            assign w_left     = w_slot[g-1];
            assign w_left_ins = w_ins[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = w_tail;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_ord_last
            assign w_order_ok[g] = 1'b1;
        end else begin : g_ord
            assign w_order_ok[g] = !w_slot[g+1].valid
                                || (w_slot[g].valid && (w_slot[g].prio >= w_slot[g+1].prio));
        end

        assign w_valid_vec[g] = w_slot[g].valid;

        spwq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_left     (w_left),
            .i_left_ins (w_left_ins),
            .i_right    (w_right),
            .i_hit      (w_hit[g]),
            .o_slot     (w_slot[g]),
            .o_ins      (w_ins[g]),
            .o_hit      (w_hit[g+1])
        );
    end

    // Tag match anywhere (chain not seeded for insert and remove)
    assign w_found    = w_hit[QUEUE_DEPTH];
    assign w_full     = w_slot[QUEUE_DEPTH-1].valid;
    assign w_front_ok = w_slot[0].valid && (w_slot[0].prio >= r_req_min);

    // Decide outcome, cell command and new occupancy
    always_comb begin
        w_status   = ST_MISS;
        w_op       = CELL_HOLD;
        w_res_tag  = '0;
        w_res_prio = '0;
        n_count    = r_count;
        unique case (r_req_action)
            ACT_INSERT: begin
                if (w_found) begin
                    w_status = ST_DUP;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_DONE;
                    w_op     = CELL_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (w_found) begin
                    w_status = ST_DONE;
                    w_op     = CELL_DELETE;
                    n_count  = r_count - 1'b1;
                end
            end
            ACT_TAKE: begin
                if (w_front_ok) begin
                    w_status   = ST_DONE;
                    w_op       = CELL_DELETE;
                    w_res_tag  = w_slot[0].tag;
                    w_res_prio = w_slot[0].prio;
                    n_count    = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer: accept in idle, execute once the result register is free
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request for the execute state
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_action <= i_action;
            r_req_tag    <= i_tag;
            r_req_prio   <= i_priority_req;
            r_req_min    <= i_min_priority;
        end
    end

    // Load the result alongside the chain update
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_tag    <= w_res_tag;
            r_out_prio   <= w_res_prio;
            r_out_count  <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_tag      = r_out_tag;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = OCC_W'(r_out_count);

    // Occupancy counter tracks the valid cells
    a_count_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(w_valid_vec)))
        else $error("occupancy counter disagrees with valid cells");

    // Valid cells form a packed prefix
    a_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec >> 1) & ~w_valid_vec) == '0)
        else $error("gap in valid cells");

    // Entries stay in descending priority order
    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order_ok)
        else $error("queue out of priority order");

    // A committed request always presents a result next cycle
    a_commit_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_out_valid && r_state == S_IDLE))
        else $error("commit without result");

endmodule
`default_nettype wire
